// ----- rtl/banded_cholesky_solver_assert.svh -----
// Assertion macros for the banded Cholesky solver.
// Included by the top level; needs no other file.
`ifndef BANDED_CHOLESKY_SOLVER_ASSERT_SVH
`define BANDED_CHOLESKY_SOLVER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define BCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// next-cycle implication, disabled while reset is held
`define BCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ----- rtl/bcs_pkg.sv -----
// Shared types and constants of the banded Cholesky solver.
// No dependencies; imported by every module of the block.
package bcs_pkg;

    localparam int MAX_FRAMES_DEF = 1024;
    localparam int MAX_DEPTH_DEF  = 4;
    localparam int FRAC_BITS_DEF  = 24;

    localparam int IDX_W  = 10;
    localparam int ROW_W  = 3;
    localparam int VAL_W  = 32;
    localparam int FC_W   = 11;
    localparam int BD_W   = 3;
    localparam int CFG_W  = 11;

    // request opcodes
    typedef enum logic [1:0] {
        OP_WR_BAND = 2'd0,
        OP_WR_RHS  = 2'd1,
        OP_SOLVE   = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    // solve outcome codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_PIVOT   = 2'd1;
    localparam logic [1:0] STAT_DIVZERO = 2'd2;

    // configuration register indexes
    localparam logic CFG_FRAME_COUNT = 1'b0;
    localparam logic CFG_BAND_DEPTH  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_READ,
        S_F_RDP, S_F_CHK, S_F_SRD, S_F_SWT, S_F_SQ, S_F_DN, S_F_DW,
        S_F_UN, S_F_UA, S_F_UB, S_F_UM, S_F_UD, S_F_UW,
        S_S_RV, S_S_WV, S_S_RT, S_S_WT, S_S_AC, S_S_WD, S_S_DW
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  frame_index;
        logic [ROW_W-1:0]  band_row;
        logic [VAL_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        logic [1:0]       status;
    } t_res;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } t_div_req;

endpackage

// ----- rtl/banded_cholesky_solver.sv -----
// Loads: one per cycle while idle and the output is not stalled; writes answer next cycle.
// A read busies the block through the vector memory read register, then the output register.
// Solve factorises column by column, then runs both substitutions, paced by divider and root.
// Reset (synchronous, active low) clears control state, status and scratch; config returns
// to frame_count 1, band_depth 2. Memory contents are undefined until written.
`include "banded_cholesky_solver_assert.svh"
module banded_cholesky_solver #(
    parameter int MAX_FRAMES = bcs_pkg::MAX_FRAMES_DEF,
    parameter int MAX_DEPTH  = bcs_pkg::MAX_DEPTH_DEF,
    parameter int FRAC_BITS  = bcs_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [47:0]               i_s_axis_tdata,  // frame_index, band_row, value, pad
    input  logic [1:0]                i_s_axis_tuser,  // op
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [31:0]               o_m_axis_tdata,  // read_value
    output logic [1:0]                o_m_axis_tuser,  // status
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [bcs_pkg::CFG_W-1:0] i_cfg_data
);
    import bcs_pkg::*;

    logic              r_m_valid;
    t_res              r_m_res;
    logic [FC_W-1:0]   r_frame_count;
    logic [BD_W-1:0]   r_band_depth;
    logic              w_accept;
    logic              w_core_idle;
    logic              w_res_valid;
    t_res              w_res;
    t_cmd              w_cmd;

    // request unpacking
    assign w_cmd.op          = t_op'(i_s_axis_tuser);
    assign w_cmd.frame_index = i_s_axis_tdata[9:0];
    assign w_cmd.band_row    = i_s_axis_tdata[12:10];
    assign w_cmd.value       = i_s_axis_tdata[44:13];

    assign o_s_axis_tready = w_core_idle && (!r_m_valid || i_m_axis_tready);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FC_W'(1);
            r_band_depth  <= BD_W'(2);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_FRAME_COUNT) begin
                r_frame_count <= i_cfg_data[FC_W-1:0];
            end else begin
                r_band_depth <= i_cfg_data[BD_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    bcs_core #(
        .MAX_FRAMES (MAX_FRAMES),
        .MAX_DEPTH  (MAX_DEPTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_accept),
        .i_cmd         (w_cmd),
        .i_frame_count (r_frame_count),
        .i_band_depth  (r_band_depth),
        .o_idle        (w_core_idle),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_res.read_value;
    assign o_m_axis_tuser  = r_m_res.status;

    // a result never lands on an undelivered one
    `BCS_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_res_valid, !r_m_valid || i_m_axis_tready)
    // writes are answered in the following cycle
    `BCS_ASSERT_NXT(a_write_answer, i_clk, i_rst_n,
        w_accept && (i_s_axis_tuser == OP_WR_BAND || i_s_axis_tuser == OP_WR_RHS), r_m_valid)
    // status stays within its defined codes
    `BCS_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tuser != 2'd3)

endmodule

// ----- rtl/bcs_sqrt.sv -----
// Iterative 64-bit integer square root, one result bit per step.
// Depends on bcs_pkg only by convention; a new start restarts any root in progress.
module bcs_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [31:0] o_root
);
    import bcs_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_x, n_x;
    logic [63:0] r_res, n_res;
    logic [63:0] r_bit, n_bit;
    logic [63:0] w_trial;

    assign w_trial = r_res + r_bit;

    // one digit step: try subtracting res + bit
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_res  = r_res;
        n_bit  = r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd31;
            n_x    = i_x;
            n_res  = '0;
            n_bit  = 64'd1 << 62;
        end else if (r_busy) begin
            if (r_x >= w_trial) begin
                n_x   = r_x - w_trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_x   <= n_x;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

// ----- rtl/bcs_div.sv -----
// Signed 64 by 32 bit restoring divider, quotient truncated toward zero.
// Uses bcs_pkg for the request struct; a new start restarts any division in progress.
module bcs_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcs_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [63:0]       o_quo
);
    import bcs_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic [32:0] w_t;
    logic        w_ge;

    assign w_t  = {r_rem, r_quo[63]};
    assign w_ge = w_t >= {1'b0, r_den};

    // magnitude setup on start, then one quotient bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd63;
            n_rem  = '0;
            n_quo  = i_req.num[63] ? (64'd0 - i_req.num) : i_req.num;
            n_den  = i_req.den[31] ? (32'd0 - i_req.den) : i_req.den;
            n_neg  = i_req.num[63] ^ i_req.den[31];
        end else if (r_busy) begin
            n_rem = w_ge ? 32'(w_t - {1'b0, r_den}) : w_t[31:0];
            n_quo = {r_quo[62:0], w_ge};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (64'd0 - r_quo) : r_quo;

endmodule

// ----- rtl/bcs_core.sv -----
// Band and vector memories with the factorise / substitute sequencer.
// Depends on bcs_pkg, bcs_sqrt and bcs_div.
module bcs_core #(
    parameter int MAX_FRAMES = bcs_pkg::MAX_FRAMES_DEF,
    parameter int MAX_DEPTH  = bcs_pkg::MAX_DEPTH_DEF,
    parameter int FRAC_BITS  = bcs_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  bcs_pkg::t_cmd            i_cmd,
    input  logic [bcs_pkg::FC_W-1:0] i_frame_count,
    input  logic [bcs_pkg::BD_W-1:0] i_band_depth,
    output logic                     o_idle,
    output logic                     o_res_valid,
    output bcs_pkg::t_res            o_res
);
    import bcs_pkg::*;

    localparam int FW     = $clog2(MAX_FRAMES);
    localparam int CW     = $clog2(MAX_FRAMES + 1);
    localparam int KW     = $clog2(MAX_DEPTH + 2);
    localparam int SW     = CW + KW + 1;
    localparam int SIW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int BDEPTH = (MAX_DEPTH + 1) * MAX_FRAMES;
    localparam int BAW    = $clog2(BDEPTH);
    localparam logic signed [64:0] ACC_MAX = 65'sd9223372036854775807;
    localparam logic signed [64:0] ACC_MIN = -ACC_MAX;

    // saturate a wide signed value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [64:0] v);
        if (v > 65'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -65'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic [BAW-1:0] baddr(input logic [KW-1:0] row,
                                             input logic [SW-1:0] col);
        return BAW'(BAW'(row) * BAW'(MAX_FRAMES)) + BAW'(col);
    endfunction

    t_state r_state, n_state;
    logic [CW-1:0]  r_c, n_c, r_pos, n_pos;
    logic [KW-1:0]  r_k, n_k, r_l, n_l;
    logic           r_bwd, n_bwd;
    logic [1:0]     r_flag, n_flag;
    logic [31:0]    r_p, n_p, r_s, n_s, r_opa, n_opa, r_opb, n_opb;
    logic [63:0]    r_acc, n_acc, r_prod;
    logic [31:0]    r_scr [MAX_DEPTH];
    logic           w_scr_we;
    logic [31:0]    w_scr_wd;

    // memories and their ports
    logic [31:0]    mem_band [BDEPTH];
    logic [31:0]    mem_vec  [MAX_FRAMES];
    logic [31:0]    r_brd, r_vrd;
    logic           w_bre, w_bwe, w_vre, w_vwe;
    logic [BAW-1:0] w_bra, w_bwa;
    logic [FW-1:0]  w_vra, w_vwa;
    logic [31:0]    w_bwd, w_vwd;

    // arithmetic units
    logic           w_sq_start, w_sq_done;
    logic [31:0]    w_root;
    t_div_req       w_div_req;
    logic           w_div_done;
    logic [63:0]    w_quo;
    logic           w_mul_en;
    logic [31:0]    w_mul_a, w_mul_b;

    // loop conditions
    logic [CW-1:0]  w_n;
    logic [KW-1:0]  w_d;
    logic [SW-1:0]  w_c1k, w_c1kl, w_tcol, w_tvec;
    logic [CW-1:0]  w_i;
    logic           w_ck_in, w_ckl_in, w_k_lt_d, w_lk_lt_d, w_c_last, w_pos_last;
    logic           w_term;
    logic           w_idx_ok, w_row_ok;
    logic [KW-1:0]  w_sidx;
    logic [31:0]    w_scr_rd;
    logic signed [64:0] w_accsum;
    logic [63:0]    w_acc_sat;

    // clamp the configured order and band depth
    always_comb begin
        if (i_frame_count == '0) begin
            w_n = CW'(1);
        end else if (32'(i_frame_count) > MAX_FRAMES) begin
            w_n = CW'(MAX_FRAMES);
        end else begin
            w_n = CW'(i_frame_count);
        end
        if (32'(i_band_depth) > MAX_DEPTH) begin
            w_d = KW'(MAX_DEPTH);
        end else begin
            w_d = KW'(i_band_depth);
        end
    end

    assign w_c1k      = SW'(r_c) + SW'(r_k) + SW'(1);
    assign w_c1kl     = w_c1k + SW'(r_l);
    assign w_ck_in    = w_c1k < SW'(w_n);
    assign w_ckl_in   = w_c1kl < SW'(w_n);
    assign w_k_lt_d   = r_k < w_d;
    assign w_lk_lt_d  = (SW'(r_l) + SW'(r_k)) < SW'(w_d);
    assign w_c_last   = (SW'(r_c) + SW'(1)) == SW'(w_n);
    assign w_pos_last = (SW'(r_pos) + SW'(1)) == SW'(w_n);
    assign w_term     = (r_k <= w_d) && (SW'(r_k) <= SW'(r_pos));
    assign w_i        = r_bwd ? (w_n - CW'(1) - r_pos) : r_pos;
    assign w_tcol     = r_bwd ? SW'(w_i) : (SW'(w_i) - SW'(r_k));
    assign w_tvec     = r_bwd ? (SW'(w_i) + SW'(r_k)) : (SW'(w_i) - SW'(r_k));
    assign w_idx_ok   = 32'(i_cmd.frame_index) < MAX_FRAMES;
    assign w_row_ok   = 32'(i_cmd.band_row) <= MAX_DEPTH;

    // single read port into the column scratch
    assign w_sidx   = (r_state == S_F_UA) ? (r_l + r_k) : r_k;
    assign w_scr_rd = r_scr[w_sidx[SIW-1:0]];

    // accumulator update with symmetric 64-bit saturation
    assign w_accsum = $signed({r_acc[63], r_acc}) - $signed({r_prod[63], r_prod});
    always_comb begin
        if (w_accsum > ACC_MAX) begin
            w_acc_sat = ACC_MAX[63:0];
        end else if (w_accsum < ACC_MIN) begin
            w_acc_sat = ACC_MIN[63:0];
        end else begin
            w_acc_sat = w_accsum[63:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_SOLVE) begin
                        n_state = S_F_RDP;
                    end else if (i_cmd.op == OP_READ && w_idx_ok) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ:  n_state = S_IDLE;
            S_F_RDP: n_state = S_F_CHK;
            S_F_CHK: n_state = ($signed(r_brd) <= 0) ? S_IDLE : S_F_SRD;
            S_F_SRD: begin
                if (!w_k_lt_d) begin
                    n_state = S_F_SQ;
                end else if (w_ck_in) begin
                    n_state = S_F_SWT;
                end
            end
            S_F_SWT: n_state = S_F_SRD;
            S_F_SQ:  n_state = w_sq_done ? S_F_DN : S_F_SQ;
            S_F_DN: begin
                if (!w_k_lt_d) begin
                    n_state = S_F_UN;
                end else if (w_ck_in) begin
                    n_state = S_F_DW;
                end
            end
            S_F_DW:  n_state = w_div_done ? S_F_DN : S_F_DW;
            S_F_UN: begin
                if (!w_k_lt_d || !w_ck_in) begin
                    n_state = w_c_last ? S_S_RV : S_F_RDP;
                end else if (w_lk_lt_d && w_ckl_in) begin
                    n_state = S_F_UA;
                end
            end
            S_F_UA:  n_state = S_F_UB;
            S_F_UB:  n_state = S_F_UM;
            S_F_UM:  n_state = S_F_UD;
            S_F_UD:  n_state = S_F_UW;
            S_F_UW:  n_state = w_div_done ? S_F_UN : S_F_UW;
            S_S_RV:  n_state = S_S_WV;
            S_S_WV:  n_state = S_S_RT;
            S_S_RT:  n_state = w_term ? S_S_WT : S_S_WD;
            S_S_WT:  n_state = S_S_AC;
            S_S_AC:  n_state = S_S_RT;
            S_S_WD:  n_state = (r_brd == '0) ? S_IDLE : S_S_DW;
            S_S_DW: begin
                if (w_div_done) begin
                    n_state = (w_pos_last && r_bwd) ? S_IDLE : S_S_RV;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory, unit and result controls
    always_comb begin
        w_bre = 1'b0;  w_bra = '0;
        w_bwe = 1'b0;  w_bwa = '0;  w_bwd = '0;
        w_vre = 1'b0;  w_vra = '0;
        w_vwe = 1'b0;  w_vwa = '0;  w_vwd = '0;
        w_sq_start = 1'b0;
        w_div_req  = '0;
        w_mul_en   = 1'b0;
        w_mul_a    = r_opa;
        w_mul_b    = r_opb;
        w_scr_we   = 1'b0;
        w_scr_wd   = '0;
        o_res_valid = 1'b0;
        o_res.read_value = '0;
        o_res.status     = r_flag;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_WR_BAND: begin
                            w_bwe = w_idx_ok && w_row_ok;
                            w_bwa = baddr(KW'(i_cmd.band_row), SW'(i_cmd.frame_index));
                            w_bwd = i_cmd.value;
                            o_res_valid = 1'b1;
                        end
                        OP_WR_RHS: begin
                            w_vwe = w_idx_ok;
                            w_vwa = FW'(i_cmd.frame_index);
                            w_vwd = i_cmd.value;
                            o_res_valid = 1'b1;
                        end
                        OP_READ: begin
                            w_vre = w_idx_ok;
                            w_vra = FW'(i_cmd.frame_index);
                            o_res_valid = !w_idx_ok;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                o_res_valid = 1'b1;
                o_res.read_value = r_vrd;
            end
            S_F_RDP: begin
                w_bre = 1'b1;
                w_bra = baddr('0, SW'(r_c));
            end
            S_F_CHK: begin
                if ($signed(r_brd) <= 0) begin
                    o_res_valid  = 1'b1;
                    o_res.status = STAT_PIVOT;
                end
            end
            S_F_SRD: begin
                if (!w_k_lt_d) begin
                    w_sq_start = 1'b1;
                end else if (w_ck_in) begin
                    w_bre = 1'b1;
                    w_bra = baddr(r_k + KW'(1), SW'(r_c));
                end else begin
                    w_scr_we = 1'b1;
                end
            end
            S_F_SWT: begin
                w_scr_we = 1'b1;
                w_scr_wd = r_brd;
            end
            S_F_SQ: begin
                w_bwe = w_sq_done;
                w_bwa = baddr('0, SW'(r_c));
                w_bwd = w_root[31] ? 32'h7FFF_FFFF : w_root;
            end
            S_F_DN: begin
                if (w_k_lt_d && w_ck_in) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = {{32{w_scr_rd[31]}}, w_scr_rd} << FRAC_BITS;
                    w_div_req.den   = r_s;
                end
            end
            S_F_DW: begin
                w_bwe = w_div_done;
                w_bwa = baddr(r_k + KW'(1), SW'(r_c));
                w_bwd = sat32($signed({w_quo[63], w_quo}));
            end
            S_F_UA: begin
                w_bre = 1'b1;
                w_bra = baddr(r_l, w_c1k);
            end
            S_F_UM: w_mul_en = 1'b1;
            S_F_UD: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = r_prod;
                w_div_req.den   = r_p;
            end
            S_F_UW: begin
                w_bwe = w_div_done;
                w_bwa = baddr(r_l, w_c1k);
                w_bwd = sat32($signed({{33{r_brd[31]}}, r_brd})
                              - $signed({w_quo[63], w_quo}));
            end
            S_S_RV: begin
                w_vre = 1'b1;
                w_vra = FW'(w_i);
            end
            S_S_RT: begin
                w_bre = 1'b1;
                if (w_term) begin
                    w_bra = baddr(r_k, w_tcol);
                    w_vre = 1'b1;
                    w_vra = FW'(w_tvec);
                end else begin
                    w_bra = baddr('0, SW'(w_i));
                end
            end
            S_S_WT: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_brd;
                w_mul_b  = r_vrd;
            end
            S_S_WD: begin
                if (r_brd == '0) begin
                    o_res_valid  = 1'b1;
                    o_res.status = STAT_DIVZERO;
                end else begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = r_acc;
                    w_div_req.den   = r_brd;
                end
            end
            S_S_DW: begin
                w_vwe = w_div_done;
                w_vwa = FW'(w_i);
                w_vwd = sat32($signed({w_quo[63], w_quo}));
                if (w_div_done && w_pos_last && r_bwd) begin
                    o_res_valid  = 1'b1;
                    o_res.status = STAT_OK;
                end
            end
            default: ;
        endcase
    end

    // counters and working registers
    always_comb begin
        n_c    = r_c;
        n_pos  = r_pos;
        n_k    = r_k;
        n_l    = r_l;
        n_bwd  = r_bwd;
        n_flag = r_flag;
        n_p    = r_p;
        n_s    = r_s;
        n_opa  = r_opa;
        n_opb  = r_opb;
        n_acc  = r_acc;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_cmd.op == OP_SOLVE) begin
                    n_c   = '0;
                    n_pos = '0;
                    n_bwd = 1'b0;
                end
            end
            S_F_CHK: begin
                n_p = r_brd;
                n_k = '0;
                if ($signed(r_brd) <= 0) begin
                    n_flag = STAT_PIVOT;
                end
            end
            S_F_SRD: begin
                if (w_k_lt_d && !w_ck_in) begin
                    n_k = r_k + KW'(1);
                end
            end
            S_F_SWT: n_k = r_k + KW'(1);
            S_F_SQ: begin
                n_s = w_root;
                n_k = '0;
            end
            S_F_DN: begin
                if (!w_k_lt_d) begin
                    n_k = '0;
                    n_l = '0;
                end else if (!w_ck_in) begin
                    n_k = r_k + KW'(1);
                end
            end
            S_F_DW: begin
                if (w_div_done) begin
                    n_k = r_k + KW'(1);
                end
            end
            S_F_UN: begin
                if (!w_k_lt_d || !w_ck_in) begin
                    n_c = r_c + CW'(1);
                end else if (!w_lk_lt_d) begin
                    n_k = r_k + KW'(1);
                    n_l = '0;
                end else if (!w_ckl_in) begin
                    n_l = r_l + KW'(1);
                end
            end
            S_F_UA: n_opa = w_scr_rd;
            S_F_UB: n_opb = w_scr_rd;
            S_F_UW: begin
                if (w_div_done) begin
                    n_l = r_l + KW'(1);
                end
            end
            S_S_WV: begin
                n_acc = {{32{r_vrd[31]}}, r_vrd} << FRAC_BITS;
                n_k   = KW'(1);
            end
            S_S_AC: begin
                n_acc = w_acc_sat;
                n_k   = r_k + KW'(1);
            end
            S_S_WD: begin
                if (r_brd == '0) begin
                    n_flag = STAT_DIVZERO;
                end
            end
            S_S_DW: begin
                if (w_div_done) begin
                    if (w_pos_last) begin
                        n_pos = '0;
                        n_bwd = 1'b1;
                        if (r_bwd) begin
                            n_flag = STAT_OK;
                        end
                    end else begin
                        n_pos = r_pos + CW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flag  <= STAT_OK;
            r_c     <= '0;
            r_pos   <= '0;
            r_k     <= '0;
            r_l     <= '0;
            r_bwd   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flag  <= n_flag;
            r_c     <= n_c;
            r_pos   <= n_pos;
            r_k     <= n_k;
            r_l     <= n_l;
            r_bwd   <= n_bwd;
        end
        r_p   <= n_p;
        r_s   <= n_s;
        r_opa <= n_opa;
        r_opb <= n_opb;
        r_acc <= n_acc;
        if (w_mul_en) begin
            r_prod <= $signed(w_mul_a) * $signed(w_mul_b);
        end
    end

    // column scratch, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_DEPTH; j++) begin
                r_scr[j] <= '0;
            end
        end else if (w_scr_we) begin
            r_scr[r_k[SIW-1:0]] <= w_scr_wd;
        end
    end

    // band memory
    always_ff @(posedge i_clk) begin
        if (w_bwe) begin
            mem_band[w_bwa] <= w_bwd;
        end
        if (w_bre) begin
            r_brd <= mem_band[w_bra];
        end
    end

    // vector memory
    always_ff @(posedge i_clk) begin
        if (w_vwe) begin
            mem_vec[w_vwa] <= w_vwd;
        end
        if (w_vre) begin
            r_vrd <= mem_vec[w_vra];
        end
    end

    bcs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_x     ({32'd0, r_p} << FRAC_BITS),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    bcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_idle = (r_state == S_IDLE);

endmodule
